// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/wbpm_pkg.sv -----
// Shared types and constants of the wildcard byte pattern matcher.
`default_nettype none

package wbpm_pkg;

	localparam int MAX_PATTERN_DEF  = 16;
	localparam int ADDRESS_BITS_DEF = 32;

	localparam int SIG_BYTES = 16;
	localparam int SIG_BITS  = SIG_BYTES * 8;
	localparam int LEN_W     = 5;
	localparam int ADDR_W    = 32;
	localparam int CFG_W     = 64;
	localparam int IDX_W     = 2;

	localparam logic [IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
	localparam logic [IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
	localparam logic [IDX_W-1:0] REG_WILDCARD     = 2'd2;
	localparam logic [IDX_W-1:0] REG_LENGTH       = 2'd3;

	// Signature settings seen by every cell of the window.
	typedef struct packed {
		logic [SIG_BITS-1:0]  pattern;
		logic [SIG_BYTES-1:0] wild;
		logic [LEN_W-1:0]     len;
	} cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/wbpm_cell.sv -----
// One window cell: holds one byte, passes it on, and checks it against its signature byte.
`default_nettype none

module wbpm_cell #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              shift,
	input  logic [7:0]        byte_in,
	input  wbpm_pkg::cfg_t    cfg,
	output logic [7:0]        byte_out,
	output logic              match
);
	import wbpm_pkg::*;

	logic [7:0]       byte_q;
	logic [LEN_W-1:0] sig_pos;
	logic [3:0]       sig_idx;
	logic [7:0]       sig_byte;

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

	// The cell at distance IDX from the newest byte lines up with signature
	// byte len - 1 - IDX; cells beyond the signature length always agree.
	assign sig_pos  = cfg.len - LEN_W'(IDX) - LEN_W'(1);
	assign sig_idx  = sig_pos[3:0];
	assign sig_byte = cfg.pattern[sig_idx*8 +: 8];

	assign byte_out = byte_q;
	assign match    = (LEN_W'(IDX) >= cfg.len) || cfg.wild[sig_idx] || (byte_q == sig_byte);

endmodule

`default_nettype wire

// ----- rtl/core/wildcard_byte_pattern_matcher.sv -----
// Top level of the wildcard byte pattern matcher: cell chain, match stage and result register.
// Each input byte is registered into the cells and the match stage, and its result into the result register.
// Throughput: one byte per cycle; a stalled result holds one more byte in the match stage,
// after which the input stalls until the result transfers.
// The match stage compares the whole window at once from the cells' registered bytes.
// Reset clears the valid flags, fill count and reported flag; len_q resets to 1.
`default_nettype none

module wildcard_byte_pattern_matcher #(
	parameter int MAX_PATTERN  = wbpm_pkg::MAX_PATTERN_DEF,
	parameter int ADDRESS_BITS = wbpm_pkg::ADDRESS_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [wbpm_pkg::IDX_W-1:0]  cfg_index,
	input  logic [wbpm_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  data_byte,
	input  logic [wbpm_pkg::ADDR_W-1:0] byte_address,
	input  logic                        region_start,
	input  logic                        stream_end,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        found,
	output logic [wbpm_pkg::ADDR_W-1:0] match_address
);
	import wbpm_pkg::*;

	localparam int FILL_W   = $clog2(MAX_PATTERN + 1);
	localparam int ADDR_KEEP = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
	localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - ADDR_KEEP);

	logic [CFG_W-1:0]     pat_low_q;
	logic [CFG_W-1:0]     pat_high_q;
	logic [SIG_BYTES-1:0] wild_q;
	logic [LEN_W-1:0]     len_q;
	logic [LEN_W-1:0]     len_eff;
	cfg_t                 cfg;

	logic                 in_xfer;
	logic                 clear_pend_q;
	logic [FILL_W-1:0]    fill_q;
	logic                 valid_s1;
	logic [ADDR_W-1:0]    addr_s1;
	logic                 send_s1;
	logic                 reported_q;
	logic                 adv_s1;
	logic                 hit;
	logic                 emit;
	logic [ADDR_W-1:0]    start_addr;

	logic                 out_valid_q;
	logic                 found_q;
	logic [ADDR_W-1:0]    match_address_q;

	logic [7:0]             win [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] cell_match;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			wild_q     <= '0;
			len_q      <= LEN_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PATTERN_LOW:  pat_low_q  <= cfg_data;
				REG_PATTERN_HIGH: pat_high_q <= cfg_data;
				REG_WILDCARD:     wild_q     <= cfg_data[SIG_BYTES-1:0];
				REG_LENGTH:       len_q      <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign len_eff = (len_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_q;

	always_comb begin
		cfg.pattern = {pat_high_q, pat_low_q};
		cfg.wild    = wild_q;
		cfg.len     = len_eff;
	end

	// The match stage holds its byte until the result register has room.
	assign adv_s1   = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_xfer  = in_valid && !in_stall;

	genvar g;
	generate
		for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
			wbpm_cell #(
				.IDX(g)
			) u_cell (
				.clk     (clk),
				.shift   (in_xfer),
				.byte_in ((g == 0) ? data_byte : win[(g == 0) ? 0 : g - 1]),
				.cfg     (cfg),
				.byte_out(win[g]),
				.match   (cell_match[g])
			);
		end
	endgenerate

	// Bytes older than the fill count never take part in a compare, so a
	// region start only has to restart the count, not wipe the cells.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			clear_pend_q <= 1'b0;
		end else if (in_xfer) begin
			clear_pend_q <= stream_end;
			if (region_start || clear_pend_q) begin
				fill_q <= FILL_W'(1);
			end else if (fill_q < FILL_W'(MAX_PATTERN)) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			addr_s1 <= byte_address;
			send_s1 <= stream_end;
		end
	end

	assign hit = valid_s1 && !reported_q && (len_eff != '0)
		&& (LEN_W'(fill_q) >= len_eff) && (&cell_match);
	assign emit       = hit || (valid_s1 && send_s1 && !reported_q);
	assign start_addr = (addr_s1 - ADDR_W'(len_eff - LEN_W'(1))) & ADDR_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reported_q <= 1'b0;
		end else if (adv_s1) begin
			if (send_s1) begin
				reported_q <= 1'b0;
			end else if (hit) begin
				reported_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			found_q         <= hit;
			match_address_q <= hit ? start_addr : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign match_address = match_address_q;

endmodule

`default_nettype wire

// ----- rtl/core/wbpm_checker.sv -----
// Port-level checker for the wildcard byte pattern matcher, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module wbpm_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_stall,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic                        found,
	input  logic [wbpm_pkg::ADDR_W-1:0] match_address
);
	import wbpm_pkg::*;

	// A stalled result stays on the port unchanged.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(found) && $stable(match_address))

	// A not-found result always carries a zero address.
	`ASSERT_IMPLIES(a_notfound_zero, clk, arst_n, out_valid && !found, match_address == '0)

	// The input only stalls behind a result that is itself stalled.
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

endmodule

bind wildcard_byte_pattern_matcher wbpm_checker u_wbpm_checker (.*);

`default_nettype wire

// ----- tb/wildcard_byte_pattern_matcher_test.sv -----
// Self-checking testbench for the wildcard byte pattern matcher: directed scans, then random ones.
`timescale 1ns / 1ps

module wildcard_byte_pattern_matcher_test;
	import wbpm_pkg::*;

	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_ITEMS  = 1500;

	typedef struct packed {
		logic [7:0]        data;
		logic [ADDR_W-1:0] addr;
		logic              region_start;
		logic              stream_end;
	} scan_byte_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] addr;
	} match_result_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cfg_write;
	logic [IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        data_byte = 8'h00;
	logic [ADDR_W-1:0] byte_address = '0;
	logic              region_start = 1'b0;
	logic              stream_end = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              found;
	logic [ADDR_W-1:0] match_address;

	// Signature settings and scan state as the block should hold them.
	logic [63:0]      sig_lo = '0;
	logic [63:0]      sig_hi = '0;
	logic [15:0]      wild_mask = '0;
	logic [LEN_W-1:0] sig_len = 5'd1;
	logic [7:0]       window_bytes [SIG_BYTES];
	int unsigned      window_fill = 0;
	bit               match_seen = 1'b0;

	scan_byte_t    pending_bytes [$];
	match_result_t awaited_results [$];
	scan_byte_t    outgoing;
	match_result_t arrived;

	bit          byte_taken = 1'b0;
	bit          calm = 1'b0;
	bit          hold_request = 1'b0;
	bit          hold_done = 1'b0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	int unsigned errors = 0;
	int unsigned cycle_count = 0;
	int unsigned bytes_taken = 0;
	int unsigned random_items = 0;
	int unsigned found_count = 0;
	int unsigned miss_count = 0;
	int unsigned input_stall_cycles = 0;
	int unsigned phase_count = 0;

	wildcard_byte_pattern_matcher dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.byte_address (byte_address),
		.region_start (region_start),
		.stream_end   (stream_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.match_address(match_address)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 40);
	endfunction

	function automatic void clear_window();
		for (int i = 0; i < SIG_BYTES; i++)
			window_bytes[i] = 8'h00;
		window_fill = 0;
	endfunction

	// Shifts one byte into the window and queues the result it should cause, if any.
	function automatic void predict_scan_byte(input scan_byte_t b);
		int unsigned n;
		bit hit;
		logic [127:0] sig;
		match_result_t r;
		n = (sig_len > SIG_BYTES) ? SIG_BYTES : sig_len;
		sig = {sig_hi, sig_lo};
		if (b.region_start)
			clear_window();
		for (int i = SIG_BYTES - 1; i > 0; i--)
			window_bytes[i] = window_bytes[i-1];
		window_bytes[0] = b.data;
		if (window_fill < SIG_BYTES)
			window_fill++;
		if (!match_seen && n > 0 && window_fill >= n) begin
			hit = 1'b1;
			for (int i = 0; i < n; i++)
				if (!wild_mask[i] && window_bytes[n-1-i] != sig[8*i +: 8])
					hit = 1'b0;
			if (hit) begin
				r.found = 1'b1;
				r.addr = b.addr - (n - 1);
				awaited_results.insert(awaited_results.size(), r);
				match_seen = 1'b1;
				found_count++;
			end
		end
		if (b.stream_end) begin
			if (!match_seen) begin
				r.found = 1'b0;
				r.addr = '0;
				awaited_results.insert(awaited_results.size(), r);
				miss_count++;
			end
			clear_window();
			match_seen = 1'b0;
		end
	endfunction

	// Sender: a held byte stays put until its transfer, then an optional gap.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !byte_taken) begin
			end else if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (pending_bytes.size() != 0) begin
				outgoing = pending_bytes.pop_front();
				in_valid <= 1'b1;
				data_byte <= outgoing.data;
				byte_address <= outgoing.addr;
				region_start <= outgoing.region_start;
				stream_end <= outgoing.stream_end;
				gap_left = calm ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
		byte_taken = 1'b0;
	end

	// Receiver: random stalls, plus one long hold-off to back the block up.
	always @(negedge clk) begin
		if (hold_request && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			stall_left = pick_gap();
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Results are checked before the byte of the same edge is predicted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					errors++;
					$display("%0t: result with none expected: found=%0b match_address=%h",
						$time, found, match_address);
				end else begin
					arrived = awaited_results.pop_front();
					if (found !== arrived.found) begin
						errors++;
						$display("%0t: found expected %0b, actual %0b",
							$time, arrived.found, found);
					end
					if (match_address !== arrived.addr) begin
						errors++;
						$display("%0t: match_address expected %h, actual %h",
							$time, arrived.addr, match_address);
					end
				end
			end
			if (in_valid && in_stall)
				input_stall_cycles++;
			if (in_valid && !in_stall) begin
				predict_scan_byte({data_byte, byte_address, region_start, stream_end});
				byte_taken = 1'b1;
				bytes_taken++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, awaited_results.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic queue_byte(input logic [7:0] data, input logic [ADDR_W-1:0] addr,
			input logic rs, input logic se);
		scan_byte_t b;
		b.data = data;
		b.addr = addr;
		b.region_start = rs;
		b.stream_end = se;
		pending_bytes.insert(pending_bytes.size(), b);
	endtask

	// Writes all four registers on consecutive cycles; unused upper data bits carry noise.
	task automatic write_config(input logic [63:0] lo, input logic [63:0] hi,
			input logic [15:0] wm, input logic [LEN_W-1:0] len);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_PATTERN_LOW;
		cfg_data <= lo;
		@(negedge clk);
		cfg_index <= REG_PATTERN_HIGH;
		cfg_data <= hi;
		@(negedge clk);
		cfg_index <= REG_WILDCARD;
		cfg_data <= {$urandom, 16'($urandom), wm};
		@(negedge clk);
		cfg_index <= REG_LENGTH;
		cfg_data <= {$urandom, 27'($urandom), len};
		@(negedge clk);
		cfg_write <= 1'b0;
		sig_lo = lo;
		sig_hi = hi;
		wild_mask = wm;
		sig_len = len;
	endtask

	// Returns once every byte has transferred, every result has arrived and the pipe has drained.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_bytes.size() != 0 || in_valid || awaited_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One scan of n bytes; most scans carry the signature somewhere inside.
	task automatic add_scan(input int unsigned n);
		int unsigned eff;
		int unsigned at;
		bit plant;
		logic [ADDR_W-1:0] addr;
		logic [127:0] sig;
		logic [7:0] data;
		eff = (sig_len > SIG_BYTES) ? SIG_BYTES : sig_len;
		sig = {sig_hi, sig_lo};
		case ($urandom_range(0, 3))
			0: addr = $urandom_range(0, 20);
			1: addr = 32'hFFFF_FFFF - $urandom_range(0, 20);
			default: addr = $urandom;
		endcase
		plant = (eff != 0) && (n >= eff) && ($urandom_range(0, 3) != 0);
		at = plant ? $urandom_range(0, n - eff) : 0;
		for (int unsigned k = 0; k < n; k++) begin
			if (plant && k >= at && k < at + eff && !wild_mask[k-at])
				data = sig[8*(k-at) +: 8];
			else if (eff != 0 && $urandom_range(0, 3) == 0)
				data = sig[8*$urandom_range(0, eff - 1) +: 8];
			else
				data = 8'($urandom);
			queue_byte(data, addr,
				(k == 0) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 24) == 0),
				k == n - 1);
			addr = ($urandom_range(0, 19) == 0) ? $urandom : addr + 1;
		end
		random_items += n;
	endtask

	function automatic int unsigned pick_scan_length();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return $urandom_range(1, 3);
		else if (r < 9)
			return $urandom_range(4, 40);
		else
			return $urandom_range(41, 120);
	endfunction

	initial begin
		logic [63:0] lo;
		logic [63:0] hi;
		logic [15:0] wm;
		logic [LEN_W-1:0] len;
		int unsigned r;
		cfg_write = 1'b0;
		cfg_index = REG_PATTERN_LOW;
		cfg_data = '0;
		clear_window();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: a one-byte signature of zero. The end byte after a match is silent.
		queue_byte(8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
		queue_byte(8'h00, 32'h0000_0000, 1'b0, 1'b0);
		queue_byte(8'h00, 32'h0000_0005, 1'b0, 1'b1);
		queue_byte(8'hAB, 32'h0000_0010, 1'b1, 1'b1);
		wait_idle();

		// Full-length signature with wildcard ends, matched on the final byte,
		// with addresses wrapping through zero.
		write_config(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908, 16'h8001, 5'd16);
		for (int k = 0; k < SIG_BYTES; k++)
			queue_byte((k == 0) ? 8'hEE : (k == SIG_BYTES - 1) ? 8'h55 : k[7:0],
				32'hFFFF_FFF9 + k, k == 0, k == SIG_BYTES - 1);
		wait_idle();

		// A zero length never matches.
		write_config({$urandom, $urandom}, {$urandom, $urandom}, 16'hFFFF, 5'd0);
		queue_byte(8'h00, 32'h1234_5678, 1'b0, 1'b0);
		queue_byte(8'hFF, 32'h1234_5679, 1'b0, 1'b1);
		wait_idle();

		// Every byte matches and ends its scan, so results pile up behind the long hold-off.
		write_config({$urandom, $urandom}, {$urandom, $urandom}, 16'h0001, 5'd1);
		hold_request = 1'b1;
		for (int k = 0; k < 40; k++)
			queue_byte(8'($urandom), $urandom, ($urandom_range(0, 1) == 1), 1'b1);
		wait_idle();

		while (random_items < RANDOM_ITEMS) begin
			if (phase_count == 0) begin
				lo = '1;
				hi = '1;
				wm = 16'hFFFF;
				len = 5'd31;
			end else if (phase_count == 1) begin
				lo = '0;
				hi = '0;
				wm = 16'h0000;
				len = 5'd16;
			end else begin
				r = $urandom_range(0, 9);
				len = (r == 0) ? 5'd0 : (r == 1) ? LEN_W'($urandom_range(17, 31)) :
					(r == 2) ? 5'd16 : (r == 3) ? 5'd1 : LEN_W'($urandom_range(1, 16));
				r = $urandom_range(0, 4);
				wm = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom & $urandom);
				r = $urandom_range(0, 5);
				lo = (r == 0) ? '0 : (r == 1) ? '1 : {$urandom, $urandom};
				hi = (r == 0) ? '0 : (r == 1) ? '1 : {$urandom, $urandom};
			end
			write_config(lo, hi, wm, len);
			calm = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(3, 8)) add_scan(pick_scan_length());
			wait_idle();
			calm = 1'b0;
			phase_count++;
		end

		errors += awaited_results.size();
		$display("%0d bytes scanned over %0d random settings, %0d cycles", bytes_taken,
			phase_count, cycle_count);
		$display("%0d matches and %0d empty scans checked, input held off for %0d cycles",
			found_count, miss_count, input_stall_cycles);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
